// ===== rtl/core/fmp_pkg.sv =====
// ----------------------------------------------------------------------------
// fmp_pkg: shared types and constants
// Default widths and the sequencer state type for the factorial-mod-prime block.
// ----------------------------------------------------------------------------
package fmp_pkg;

	localparam int unsigned MOD_BITS_DEF   = 16;
	localparam int unsigned COUNT_BITS_DEF = 60;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_CHOOSE,
		ST_MUL,
		ST_FIN
	} state_t;

endpackage

// ===== rtl/core/factorial_mod_prime_skip_multiples_top.sv =====
// ----------------------------------------------------------------------------
// factorial_mod_prime_skip_multiples_top: product of non-multiples mod a prime
// Splits the count by the modulus, builds r! mod m by repeated modular
// multiplication and negates it when the quotient is odd (Wilson's theorem).
// ----------------------------------------------------------------------------
//
//   Channel | Handshake            | Fields
//   --------+----------------------+------------------------------
//   input   | in_valid / in_ready  | count_t [COUNT_BITS], modulus [MOD_BITS]
//   output  | out_valid / out_ready| residue [MOD_BITS]
//
// Per item: the transfer is taken, restoring division splits the count, each
// factor from 2 to r, and once more when the quotient is odd, goes through
// a choose state and a multiply pass, all on the one shift-add-reduce step in
// fmp_modstep, then the finish state; a zero modulus goes straight to finish.
// Reset clears the sequencer and the output valid. in_ready is high only in
// idle, and a result that finds the output register still full waits in finish.
// ----------------------------------------------------------------------------
module factorial_mod_prime_skip_multiples_top #(
	parameter int unsigned MOD_BITS   = fmp_pkg::MOD_BITS_DEF,
	parameter int unsigned COUNT_BITS = fmp_pkg::COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COUNT_BITS-1:0] count_t,
	input  logic [MOD_BITS-1:0]   modulus,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [MOD_BITS-1:0]   residue
);

	localparam int unsigned CNT_MAX = (COUNT_BITS > MOD_BITS) ? COUNT_BITS : MOD_BITS;
	localparam int unsigned CNT_W   = $clog2(CNT_MAX);

	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(COUNT_BITS - 1);
	localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MOD_BITS - 1);
	localparam logic [MOD_BITS-1:0] ONE   = MOD_BITS'(1);
	localparam logic [MOD_BITS-1:0] TWO   = MOD_BITS'(2);

	fmp_pkg::state_t state_q, state_d;

	// Working registers.
	logic [COUNT_BITS-1:0] t_q;      // count, shifted out MSB first
	logic [MOD_BITS-1:0]   m_q;      // modulus
	logic [MOD_BITS-1:0]   p_q;      // running remainder / partial product
	logic [MOD_BITS-1:0]   r_q;      // count mod modulus
	logic [MOD_BITS-1:0]   acc_q;    // factorial accumulator
	logic [MOD_BITS-1:0]   k_q;      // next factorial term
	logic [MOD_BITS-1:0]   mul_b_q;  // multiplier, shifted out MSB first
	logic [CNT_W-1:0]      cnt_q;    // bit counter
	logic                  odd_q;    // quotient is odd and negation still pending
	logic                  out_valid_q;
	logic [MOD_BITS-1:0]   residue_q;

	logic                  in_xfer;
	logic                  out_free;
	logic [MOD_BITS-1:0]   step_b;
	logic [MOD_BITS-1:0]   step_res;
	logic                  step_ge;
	logic                  cnt_done;
	logic                  term_left;

	assign in_xfer   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign cnt_done  = (cnt_q == '0);
	assign term_left = (k_q <= r_q);

	// The shared unit: during division the addend is the next count bit,
	// during multiplication it is the accumulator when the multiplier bit is set.
	always_comb begin
		case (state_q)
			fmp_pkg::ST_DIV: step_b = {{(MOD_BITS-1){1'b0}}, t_q[COUNT_BITS-1]};
			fmp_pkg::ST_MUL: step_b = mul_b_q[MOD_BITS-1] ? acc_q : '0;
			default:         step_b = '0;
		endcase
	end

	fmp_modstep #(
		.MOD_BITS (MOD_BITS)
	) u_step (
		.a   (p_q),
		.b   (step_b),
		.m   (m_q),
		.res (step_res),
		.ge  (step_ge)
	);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			fmp_pkg::ST_IDLE: begin
				if (in_xfer) begin
					state_d = (modulus == '0) ? fmp_pkg::ST_FIN : fmp_pkg::ST_DIV;
				end
			end
			fmp_pkg::ST_DIV: begin
				if (cnt_done) begin
					state_d = fmp_pkg::ST_CHOOSE;
				end
			end
			fmp_pkg::ST_CHOOSE: begin
				if (term_left || odd_q) begin
					state_d = fmp_pkg::ST_MUL;
				end else begin
					state_d = fmp_pkg::ST_FIN;
				end
			end
			fmp_pkg::ST_MUL: begin
				if (cnt_done) begin
					state_d = fmp_pkg::ST_CHOOSE;
				end
			end
			fmp_pkg::ST_FIN: begin
				if (out_free) begin
					state_d = fmp_pkg::ST_IDLE;
				end
			end
			default: state_d = fmp_pkg::ST_IDLE;
		endcase
	end

	// Output logic.
	always_comb begin
		in_ready  = (state_q == fmp_pkg::ST_IDLE);
		out_valid = out_valid_q;
		residue   = residue_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fmp_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == fmp_pkg::ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers; their contents only matter once the sequencer loads them.
	always_ff @(posedge clk) begin
		case (state_q)
			fmp_pkg::ST_IDLE: begin
				if (in_xfer) begin
					t_q   <= count_t;
					m_q   <= modulus;
					p_q   <= '0;
					acc_q <= '0;
					odd_q <= 1'b0;
					cnt_q <= DIV_LAST;
				end
			end
			fmp_pkg::ST_DIV: begin
				p_q   <= step_res;
				t_q   <= {t_q[COUNT_BITS-2:0], 1'b0};
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_done) begin
					// The last quotient bit decides the sign.
					odd_q <= step_ge;
					r_q   <= step_res;
					k_q   <= TWO;
					acc_q <= (m_q == ONE) ? '0 : ONE;
				end
			end
			fmp_pkg::ST_CHOOSE: begin
				p_q   <= '0;
				cnt_q <= MUL_LAST;
				if (term_left) begin
					mul_b_q <= k_q;
					k_q     <= k_q + ONE;
				end else if (odd_q) begin
					mul_b_q <= m_q - ONE;
					odd_q   <= 1'b0;
				end
			end
			fmp_pkg::ST_MUL: begin
				p_q     <= step_res;
				mul_b_q <= {mul_b_q[MOD_BITS-2:0], 1'b0};
				cnt_q   <= cnt_q - CNT_W'(1);
				if (cnt_done) begin
					acc_q <= step_res;
				end
			end
			fmp_pkg::ST_FIN: begin
				if (out_free) begin
					residue_q <= acc_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/core/fmp_modstep.sv =====
// ----------------------------------------------------------------------------
// fmp_modstep: shared modular shift-add step
// Computes (2*a + b) mod m for a < m and b < m by subtracting 2*m, m or nothing.
// ----------------------------------------------------------------------------
module fmp_modstep #(
	parameter int unsigned MOD_BITS = fmp_pkg::MOD_BITS_DEF
) (
	input  logic [MOD_BITS-1:0] a,
	input  logic [MOD_BITS-1:0] b,
	input  logic [MOD_BITS-1:0] m,
	output logic [MOD_BITS-1:0] res,
	output logic                ge
);

	localparam int unsigned W = MOD_BITS + 2;

	logic [W-1:0] sum;
	logic [W-1:0] m1;
	logic [W-1:0] m2;
	logic [W-1:0] red;

	always_comb begin
		sum = {1'b0, a, 1'b0} + {2'b00, b};
		m1  = {2'b00, m};
		m2  = {1'b0, m, 1'b0};
		ge  = (sum >= m1);
		// The sum stays below three times the modulus, so two compares suffice.
		if (sum >= m2) begin
			red = sum - m2;
		end else if (ge) begin
			red = sum - m1;
		end else begin
			red = sum;
		end
		res = red[MOD_BITS-1:0];
	end

endmodule

// ===== rtl/core/fmp_checker.sv =====
// ----------------------------------------------------------------------------
// fmp_checker: port-level checks for the factorial-mod-prime block
// Watches the top-level ports only and is bound to every instance of the top.
// ----------------------------------------------------------------------------
module fmp_checker #(
	parameter int unsigned MOD_BITS   = fmp_pkg::MOD_BITS_DEF,
	parameter int unsigned COUNT_BITS = fmp_pkg::COUNT_BITS_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic [COUNT_BITS-1:0] count_t,
	input logic [MOD_BITS-1:0]   modulus,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [MOD_BITS-1:0]   residue
);

	// A stalled result keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(residue))
		else $error("residue changed while stalled");

	// Once an item is taken the block is busy with it.
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in progress");

	// A new result appears only as the sequencer returns to idle.
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result presented while still busy");

	// No result can be produced in the cycle right after an input transfer.
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared too early");

endmodule

bind factorial_mod_prime_skip_multiples_top fmp_checker #(
	.MOD_BITS   (MOD_BITS),
	.COUNT_BITS (COUNT_BITS)
) u_fmp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.count_t   (count_t),
	.modulus   (modulus),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.residue   (residue)
);
